// ===== hw/rtl/vtc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vtc_pkg
// Types, codes and lookup functions for the value type classifier.
// ============================================================================
package vtc_pkg;

    localparam int CHAR_W  = 8;
    localparam int CLASS_W = 4;
    localparam int STAGE_W = 2;
    localparam int LEN_W   = 3;
    localparam int TYPE_W  = 8;

    localparam logic [LEN_W-1:0] LEN_MAX = 3'd5;

    localparam logic [CLASS_W-1:0] CLS_NONE      = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_BOOL      = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_REF       = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_INT       = 4'd3;
    localparam logic [CLASS_W-1:0] CLS_DEC       = 4'd4;
    localparam logic [CLASS_W-1:0] CLS_STR       = 4'd5;
    localparam logic [CLASS_W-1:0] CLS_BOOL_LIST = 4'd6;
    localparam logic [CLASS_W-1:0] CLS_REF_LIST  = 4'd7;
    localparam logic [CLASS_W-1:0] CLS_INT_LIST  = 4'd8;
    localparam logic [CLASS_W-1:0] CLS_DEC_LIST  = 4'd9;
    localparam logic [CLASS_W-1:0] CLS_STR_LIST  = 4'd10;
    localparam logic [CLASS_W-1:0] CLS_QUAD      = 4'd11;
    localparam logic [CLASS_W-1:0] CLS_QUAD_LIST = 4'd12;
    localparam logic [CLASS_W-1:0] CLS_LIST_OFS  = 4'd5;

    localparam logic [STAGE_W-1:0] STAGE_NONE  = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_LIST  = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_ENDED = 2'd2;

    localparam logic [TYPE_W-1:0] TYPE_INT       = 8'd1;
    localparam logic [TYPE_W-1:0] TYPE_BOOL      = 8'd2;
    localparam logic [TYPE_W-1:0] TYPE_DEC       = 8'd3;
    localparam logic [TYPE_W-1:0] TYPE_STR       = 8'd4;
    localparam logic [TYPE_W-1:0] TYPE_QUAD      = 8'd9;
    localparam logic [TYPE_W-1:0] TYPE_REF       = 8'd14;
    localparam logic [TYPE_W-1:0] TYPE_REF_LIST  = 8'd15;
    localparam logic [TYPE_W-1:0] TYPE_INT_LIST  = 8'd20;
    localparam logic [TYPE_W-1:0] TYPE_DEC_LIST  = 8'd21;
    localparam logic [TYPE_W-1:0] TYPE_STR_LIST  = 8'd22;
    localparam logic [TYPE_W-1:0] TYPE_BOOL_LIST = 8'd23;
    localparam logic [TYPE_W-1:0] TYPE_QUAD_LIST = 8'd24;
    localparam logic [TYPE_W-1:0] TYPE_EMPTY     = 8'd251;

    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A      = 8'h61;
    localparam logic [CHAR_W-1:0] CH_E      = 8'h65;
    localparam logic [CHAR_W-1:0] CH_F      = 8'h66;
    localparam logic [CHAR_W-1:0] CH_L      = 8'h6C;
    localparam logic [CHAR_W-1:0] CH_R      = 8'h72;
    localparam logic [CHAR_W-1:0] CH_S      = 8'h73;
    localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
    localparam logic [CHAR_W-1:0] CH_U      = 8'h75;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [STAGE_W-1:0] stage;
        logic               open;
        logic               exp_true;
        logic [LEN_W-1:0]   len;
        logic               settled;
    } detect_state_t;

    localparam detect_state_t STATE_RESET = '{
        cls: CLS_NONE, stage: STAGE_NONE, open: 1'b0,
        exp_true: 1'b0, len: '0, settled: 1'b0
    };

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Character c at position pos matches the expected bool word.
    function automatic logic bool_match(
        input logic              exp_true,
        input logic [LEN_W-1:0]  pos,
        input logic [CHAR_W-1:0] c
    );
        logic ok;
        ok = 1'b0;
        if (exp_true) begin
            case (pos)
                3'd0:    ok = (c == CH_T);
                3'd1:    ok = (c == CH_R);
                3'd2:    ok = (c == CH_U);
                3'd3:    ok = (c == CH_E);
                default: ok = 1'b0;
            endcase
        end else begin
            case (pos)
                3'd0:    ok = (c == CH_F);
                3'd1:    ok = (c == CH_A);
                3'd2:    ok = (c == CH_L);
                3'd3:    ok = (c == CH_S);
                3'd4:    ok = (c == CH_E);
                default: ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

    function automatic logic [TYPE_W-1:0] class_code(input logic [CLASS_W-1:0] cls);
        logic [TYPE_W-1:0] code;
        case (cls)
            CLS_BOOL:      code = TYPE_BOOL;
            CLS_REF:       code = TYPE_REF;
            CLS_INT:       code = TYPE_INT;
            CLS_DEC:       code = TYPE_DEC;
            CLS_STR:       code = TYPE_STR;
            CLS_BOOL_LIST: code = TYPE_BOOL_LIST;
            CLS_REF_LIST:  code = TYPE_REF_LIST;
            CLS_INT_LIST:  code = TYPE_INT_LIST;
            CLS_DEC_LIST:  code = TYPE_DEC_LIST;
            CLS_STR_LIST:  code = TYPE_STR_LIST;
            CLS_QUAD:      code = TYPE_QUAD;
            CLS_QUAD_LIST: code = TYPE_QUAD_LIST;
            default:       code = TYPE_EMPTY;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/value_type_classifier.sv =====
`timescale 1ns / 1ps
// ============================================================================
// value_type_classifier
// Classifies a character stream into a content type code, one character per
// cycle while in_stall is low; a result leaves on the transaction marked last.
// ============================================================================
//  Channel | Signals                            | Direction
//  --------+------------------------------------+----------
//  input   | in_valid, in_stall, char_in,       | in
//          | no_char, last                      |
//  output  | out_valid, out_stall, content_type | out
//
//  One input transaction per cycle while in_stall is low; the detector state
//  updates in the cycle of acceptance and each result is registered in a result entry.
//  A result register plus one skid entry decouple the sides: in_stall rises
//  only while the skid entry holds a result that is waiting.
//  Reset clears the detector state and both result entries.
// ============================================================================
module value_type_classifier (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [vtc_pkg::CHAR_W-1:0]  char_in,
    input  logic                        no_char,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [vtc_pkg::TYPE_W-1:0]  content_type
);
    import vtc_pkg::*;

    detect_state_t     st_reg;
    detect_state_t     st_next;
    detect_state_t     upd;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [TYPE_W-1:0] out_type_reg;
    logic [TYPE_W-1:0] out_type_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [TYPE_W-1:0] skid_type_reg;
    logic [TYPE_W-1:0] skid_type_next;
    logic              in_take;
    logic              out_take;
    logic              res_new;
    logic [TYPE_W-1:0] res_type;

    assign in_stall     = skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign content_type = out_type_reg;
    assign in_take      = in_valid && !skid_valid_reg;
    assign out_take     = out_valid_reg && !out_stall;

    // Detector update for one character.
    always_comb
    begin
        upd = st_reg;
        if (!no_char && !st_reg.settled) begin
            if (!st_reg.open) begin
                if (!is_space(char_in)) begin
                    upd.open = 1'b1;
                    upd.len  = 3'd1;
                    if (st_reg.stage == STAGE_ENDED) begin
                        upd.stage   = STAGE_LIST;
                        upd.settled = 1'b1;
                        if (st_reg.cls < CLS_QUAD) begin
                            upd.cls = st_reg.cls + CLS_LIST_OFS;
                        end else if (st_reg.cls == CLS_QUAD) begin
                            upd.cls = CLS_QUAD_LIST;
                        end
                    end else if (char_in == CH_T) begin
                        upd.exp_true = 1'b1;
                        upd.cls      = CLS_BOOL;
                    end else if (char_in == CH_F) begin
                        upd.exp_true = 1'b0;
                        upd.cls      = CLS_BOOL;
                    end else if (char_in == CH_MINUS || is_digit(char_in)) begin
                        upd.cls = CLS_INT;
                    end else if (char_in == CH_HASH) begin
                        upd.cls = CLS_REF;
                    end else if (char_in == CH_LPAREN) begin
                        upd.cls = CLS_QUAD;
                    end else begin
                        upd.cls = CLS_STR;
                    end
                end
            end else if (st_reg.cls == CLS_QUAD) begin
                if (char_in == CH_RPAREN) begin
                    upd.open  = 1'b0;
                    upd.stage = STAGE_ENDED;
                end
            end else if (is_space(char_in)) begin
                upd.open  = 1'b0;
                upd.stage = STAGE_ENDED;
            end else begin
                if (st_reg.len < LEN_MAX) begin
                    upd.len = st_reg.len + 3'd1;
                end
                case (st_reg.cls)
                    CLS_BOOL:
                    begin
                        if (!bool_match(st_reg.exp_true, st_reg.len, char_in)) begin
                            upd.cls = CLS_STR;
                        end
                    end
                    CLS_INT:
                    begin
                        if (char_in == CH_DOT) begin
                            upd.cls = CLS_DEC;
                        end else if (!is_digit(char_in)) begin
                            upd.cls = CLS_STR;
                        end
                    end
                    CLS_DEC:
                    begin
                        if (!is_digit(char_in)) begin
                            upd.cls = CLS_STR;
                        end
                    end
                    default:
                    begin
                        upd.cls = st_reg.cls;
                    end
                endcase
            end
        end
    end

    assign res_new  = in_take && last;
    assign res_type = class_code(upd.cls);

    // Advance state, route results through output and skid entries.
    always_comb
    begin
        st_next         = st_reg;
        out_valid_next  = out_valid_reg;
        out_type_next   = out_type_reg;
        skid_valid_next = skid_valid_reg;
        skid_type_next  = skid_type_reg;

        if (in_take) begin
            st_next = last ? STATE_RESET : upd;
        end

        if (out_take) begin
            out_valid_next  = skid_valid_reg;
            out_type_next   = skid_type_reg;
            skid_valid_next = 1'b0;
        end

        if (res_new) begin
            if (!out_valid_reg || out_take) begin
                out_valid_next = 1'b1;
                out_type_next  = res_type;
            end else begin
                skid_valid_next = 1'b1;
                skid_type_next  = res_type;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg         <= STATE_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            st_reg         <= st_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_type_reg  <= out_type_next;
        skid_type_reg <= skid_type_next;
    end

endmodule
